// File: design/gtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gtc_pkg;

  // Default sizes of the glyph store.
  localparam int GLYPH_COUNT_DEF    = 256;
  localparam int MAX_GLYPH_ROWS_DEF = 32;

  // Widest glyph cell; columns past the mask width never carry ink.
  localparam int MAX_GLYPH_WIDTH = 16;
  localparam int MASK_W          = 16;

  // Register reset values.
  localparam logic [11:0] FB_WIDTH_RST     = 12'd640;
  localparam logic [11:0] FB_HEIGHT_RST    = 12'd480;
  localparam logic [4:0]  GLYPH_WIDTH_RST  = 5'd8;
  localparam logic [5:0]  GLYPH_HEIGHT_RST = 6'd16;
  localparam logic [6:0]  LINE_HEIGHT_RST  = 7'd16;
  localparam logic [11:0] LEFT_MARGIN_RST  = 12'd20;
  localparam logic [11:0] TOP_MARGIN_RST   = 12'd15;

  // Character codes with special meaning.
  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_RETURN   = 8'h0D;
  localparam logic [7:0] CH_QUESTION = 8'h3F;

  // Cursor y saturates here.
  localparam logic [11:0] Y_LIMIT = 12'hFFF;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_FB_WIDTH     = 3'd0,
    REG_FB_HEIGHT    = 3'd1,
    REG_GLYPH_WIDTH  = 3'd2,
    REG_GLYPH_HEIGHT = 3'd3,
    REG_LINE_HEIGHT  = 3'd4,
    REG_LEFT_MARGIN  = 3'd5,
    REG_TOP_MARGIN   = 3'd6
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_NEWLINE,
    ST_BOTTOM,
    ST_ROOM,
    ST_ROW,
    ST_ADVANCE,
    ST_WRAP
  } seq_state_t;

  // Operations of the shared add/compare unit.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [12:0] a;
    logic [12:0] b;
    logic [11:0] lim;
  } alu_req_t;

  typedef struct packed {
    logic [13:0] value;
    logic        flag;
  } alu_res_t;

  // Working configuration, glyph size already clamped.
  typedef struct packed {
    logic [11:0] fb_width;
    logic [11:0] fb_height;
    logic [5:0]  gw;
    logic [6:0]  gh;
    logic [6:0]  line_step;
    logic [11:0] margin_x;
  } cfg_t;

  // Bit c of the result is bit 15 minus c of the stored row.
  function automatic logic [MASK_W-1:0] rev16(input logic [MASK_W-1:0] v);
    logic [MASK_W-1:0] r;
    for (int i = 0; i < MASK_W; i++) begin
      r[i] = v[MASK_W-1-i];
    end
    return r;
  endfunction

  // Mask with the low cols bits set.
  function automatic logic [MASK_W-1:0] below_mask(input logic [4:0] cols);
    logic [MASK_W-1:0] m;
    for (int i = 0; i < MASK_W; i++) begin
      m[i] = (5'(i) < cols);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: design/glyph_text_console_renderer.sv
`timescale 1ns / 1ps
`default_nettype none

// Text console renderer: a draw item (req_type 1) yields one result beat per glyph row,
// with the row's pixel mask placed at the text cursor, or none for newline, carriage
// return or a cell dropped below the bottom edge; a load item (req_type 0) writes one
// glyph row into the on-chip glyph store, yields nothing and leaves the block ready for
// the next item. A drawn character passes the sequencer states check, bottom, room, row
// per glyph row, advance and wrap, with newline on a wrap; every cursor step uses one
// shared add/compare unit, and one glyph row per cycle is read from the store's single
// read port while the result side does not stall. The glyph store powers up unwritten
// and needs no clearing pass; drawing a row that was never loaded gives an undefined mask.
module glyph_text_console_renderer #(
  parameter int GLYPH_COUNT    = gtc_pkg::GLYPH_COUNT_DEF,
  parameter int MAX_GLYPH_ROWS = gtc_pkg::MAX_GLYPH_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  // Item channel
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic        req_type,
  input  wire logic [20:0] code,
  input  wire logic [4:0]  row_index,
  input  wire logic [15:0] row_bits,
  input  wire logic [31:0] ink_color,
  // Result channel
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [11:0]      pos_x,
  output logic [11:0]      pos_y,
  output logic [15:0]      pixel_mask,
  output logic [31:0]      out_color,
  output logic             clear_rest,
  output logic             last
);
  import gtc_pkg::*;

  localparam int Depth  = GLYPH_COUNT * MAX_GLYPH_ROWS;
  localparam int AddrW  = $clog2(Depth);
  localparam logic [5:0] MaxGw = 6'(MAX_GLYPH_WIDTH);
  localparam logic [6:0] MaxGh = 7'(MAX_GLYPH_ROWS);

  logic [11:0] fb_width;
  logic [11:0] fb_height;
  logic [4:0]  glyph_width;
  logic [5:0]  glyph_height;
  logic [6:0]  line_step;
  logic [11:0] margin_x;

  cfg_t        cfg;
  alu_req_t    alu_req;
  alu_res_t    alu_res;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [15:0]      ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [15:0]      ram_rdata;
  logic [4:0]       gw_cols;
  logic [15:0]      gw_mask;

  // Configuration registers. Top margin only sets the cursor at reset, so it is not held.
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width     <= FB_WIDTH_RST;
      fb_height    <= FB_HEIGHT_RST;
      glyph_width  <= GLYPH_WIDTH_RST;
      glyph_height <= GLYPH_HEIGHT_RST;
      line_step    <= LINE_HEIGHT_RST;
      margin_x     <= LEFT_MARGIN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FB_WIDTH:     fb_width     <= cfg_data;
        REG_FB_HEIGHT:    fb_height    <= cfg_data;
        REG_GLYPH_WIDTH:  glyph_width  <= cfg_data[4:0];
        REG_GLYPH_HEIGHT: glyph_height <= cfg_data[5:0];
        REG_LINE_HEIGHT:  line_step    <= cfg_data[6:0];
        REG_LEFT_MARGIN:  margin_x     <= cfg_data;
        REG_TOP_MARGIN: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Working configuration with the glyph size clamped to what the store holds.
  always_comb begin
    cfg.fb_width  = fb_width;
    cfg.fb_height = fb_height;
    cfg.line_step = line_step;
    cfg.margin_x  = margin_x;
    if (glyph_width == 5'd0) begin
      cfg.gw = 6'd1;
    end else if (6'(glyph_width) > MaxGw) begin
      cfg.gw = MaxGw;
    end else begin
      cfg.gw = 6'(glyph_width);
    end
    if (glyph_height == 6'd0) begin
      cfg.gh = 7'd1;
    end else if (7'(glyph_height) > MaxGh) begin
      cfg.gh = MaxGh;
    end else begin
      cfg.gh = 7'(glyph_height);
    end
  end

  gtc_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  gtc_glyph_ram #(
    .DEPTH  (Depth),
    .ADDR_W (AddrW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gtc_seq #(
    .GLYPH_COUNT    (GLYPH_COUNT),
    .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS),
    .ADDR_W         (AddrW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .code       (code),
    .row_index  (row_index),
    .row_bits   (row_bits),
    .ink_color  (ink_color),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pixel_mask (pixel_mask),
    .out_color  (out_color),
    .clear_rest (clear_rest),
    .last       (last),
    .alu_req    (alu_req),
    .alu_res    (alu_res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // Columns inside the glyph cell, for checking.
  assign gw_cols = (cfg.gw > 6'(MASK_W)) ? 5'(MASK_W) : cfg.gw[4:0];
  assign gw_mask = below_mask(gw_cols);

  // A character still has rows to send, so no new item is taken.
  a_busy_mid_char: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> req_stall)
    else $error("item channel open while a character is half sent");

  // Rows of one character follow each other without a gap.
  a_rows_back_to_back: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && !last |=> res_valid)
    else $error("gap between rows of one character");

  // Ink never lands outside the glyph cell.
  a_mask_in_cell: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((pixel_mask & ~gw_mask) == 16'd0))
    else $error("pixel mask reaches past the glyph width");

endmodule

`default_nettype wire

// File: design/gtc_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module gtc_alu (
  input  wire gtc_pkg::alu_req_t req,
  output gtc_pkg::alu_res_t      res
);
  import gtc_pkg::*;

  // One adder/subtractor with a compare, shared by every sequencer step.
  always_comb begin
    case (req.op)
      ALU_SUB: begin
        res.value = {1'b0, req.a} - {1'b0, req.b};
        res.flag  = (req.a < req.b);
      end
      default: begin
        res.value = {1'b0, req.a} + {1'b0, req.b};
        res.flag  = (res.value > {2'b00, req.lim});
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/gtc_glyph_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gtc_glyph_ram #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [15:0]       wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic [15:0]            rdata
);

  logic [15:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/gtc_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module gtc_seq #(
  parameter int GLYPH_COUNT    = 256,
  parameter int MAX_GLYPH_ROWS = 32,
  parameter int ADDR_W         = $clog2(GLYPH_COUNT * MAX_GLYPH_ROWS)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gtc_pkg::cfg_t     cfg,
  // Item channel
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic              req_type,
  input  wire logic [20:0]       code,
  input  wire logic [4:0]        row_index,
  input  wire logic [15:0]       row_bits,
  input  wire logic [31:0]       ink_color,
  // Result channel
  output logic                   res_valid,
  input  wire logic              res_stall,
  output logic [11:0]            pos_x,
  output logic [11:0]            pos_y,
  output logic [15:0]            pixel_mask,
  output logic [31:0]            out_color,
  output logic                   clear_rest,
  output logic                   last,
  // Shared arithmetic unit
  output gtc_pkg::alu_req_t      alu_req,
  input  wire gtc_pkg::alu_res_t alu_res,
  // Glyph store
  output logic                   ram_we,
  output logic [ADDR_W-1:0]      ram_waddr,
  output logic [15:0]            ram_wdata,
  output logic [ADDR_W-1:0]      ram_raddr,
  input  wire logic [15:0]       ram_rdata
);
  import gtc_pkg::*;

  localparam int GIW = $clog2(GLYPH_COUNT);
  localparam logic [8:0] GlyphLimit = 9'(GLYPH_COUNT);
  localparam logic [6:0] RowLimit   = 7'(MAX_GLYPH_ROWS);

  seq_state_t  state, state_next;
  logic [11:0] cursor_x, cursor_x_next;
  logic [11:0] cursor_y, cursor_y_next;
  logic        overwrite, overwrite_next;
  logic        nl_post, nl_post_next;
  logic [7:0]  item_code, item_code_next;
  logic [31:0] item_color, item_color_next;
  logic [5:0]  row, row_next;
  logic [15:0] col_mask, col_mask_next;
  logic [12:0] adv_x, adv_x_next;
  logic        res_valid_next;
  logic [11:0] pos_x_next, pos_y_next;
  logic [15:0] pixel_mask_next;
  logic [31:0] out_color_next;
  logic        clear_rest_next, last_next;

  logic        accept;
  logic        out_free;
  logic        glyph_ok;
  logic        row_last;
  logic [7:0]  load_glyph;
  logic        load_ok;
  logic [12:0] room;
  logic [12:0] room_cols;
  logic [4:0]  cols;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !res_valid || !res_stall;
  assign glyph_ok  = ({1'b0, item_code} < GlyphLimit);
  assign row_last  = ((7'(row) + 7'd1) == cfg.gh);

  // Glyph row loads go straight into the store in the cycle they are taken.
  assign load_glyph = code[7:0];
  assign load_ok    = ({1'b0, load_glyph} < GlyphLimit) && (7'(row_index) < RowLimit);
  assign ram_we     = accept && !req_type && load_ok;
  assign ram_waddr  = ADDR_W'(int'(load_glyph[GIW-1:0]) * MAX_GLYPH_ROWS + int'(row_index));
  assign ram_wdata  = row_bits;

  // Read address follows the next row so data lines up with the row register.
  assign ram_raddr  = ADDR_W'(int'(item_code[GIW-1:0]) * MAX_GLYPH_ROWS + int'(row_next));

  // Visible columns of the cell: the smaller of room, glyph width and mask width.
  assign room      = alu_res.flag ? 13'd0 : alu_res.value[12:0];
  assign room_cols = (room < 13'(cfg.gw)) ? room : 13'(cfg.gw);
  assign cols      = (room_cols > 13'(MASK_W)) ? 5'(MASK_W) : room_cols[4:0];

  // Next state, arithmetic requests and register updates.
  always_comb begin
    state_next      = state;
    cursor_x_next   = cursor_x;
    cursor_y_next   = cursor_y;
    overwrite_next  = overwrite;
    nl_post_next    = nl_post;
    item_code_next  = item_code;
    item_color_next = item_color;
    row_next        = row;
    col_mask_next   = col_mask;
    adv_x_next      = adv_x;
    res_valid_next  = res_valid && res_stall;
    pos_x_next      = pos_x;
    pos_y_next      = pos_y;
    pixel_mask_next = pixel_mask;
    out_color_next  = out_color;
    clear_rest_next = clear_rest;
    last_next       = last;
    alu_req.op      = ALU_ADD;
    alu_req.a       = 13'(cursor_x);
    alu_req.b       = 13'(cfg.gw);
    alu_req.lim     = cfg.fb_width;

    case (state)
      ST_IDLE: begin
        if (accept && req_type) begin
          item_code_next  = (code > 21'd255) ? CH_QUESTION : code[7:0];
          item_color_next = ink_color;
          state_next      = ST_CHECK;
        end
      end

      // Control codes, and the right edge test before drawing.
      ST_CHECK: begin
        if (item_code == CH_NEWLINE) begin
          overwrite_next = 1'b0;
          nl_post_next   = 1'b1;
          state_next     = ST_NEWLINE;
        end else if (item_code == CH_RETURN) begin
          cursor_x_next  = cfg.margin_x;
          overwrite_next = 1'b1;
          state_next     = ST_IDLE;
        end else if (alu_res.flag) begin
          overwrite_next = 1'b0;
          nl_post_next   = 1'b0;
          state_next     = ST_NEWLINE;
        end else begin
          state_next = ST_BOTTOM;
        end
      end

      // Return to the margin and step down one line, saturating.
      ST_NEWLINE: begin
        alu_req.a     = 13'(cursor_y);
        alu_req.b     = 13'(cfg.line_step);
        alu_req.lim   = Y_LIMIT;
        cursor_x_next = cfg.margin_x;
        cursor_y_next = alu_res.flag ? Y_LIMIT : alu_res.value[11:0];
        state_next    = nl_post ? ST_IDLE : ST_BOTTOM;
      end

      // A cell below the bottom edge is dropped.
      ST_BOTTOM: begin
        alu_req.a   = 13'(cursor_y);
        alu_req.b   = 13'(cfg.gh);
        alu_req.lim = cfg.fb_height;
        state_next  = alu_res.flag ? ST_IDLE : ST_ROOM;
      end

      // Room to the right edge sets the column mask; row 0 is read here.
      ST_ROOM: begin
        alu_req.op    = ALU_SUB;
        alu_req.a     = 13'(cfg.fb_width);
        alu_req.b     = 13'(cursor_x);
        col_mask_next = below_mask(cols);
        row_next      = 6'd0;
        state_next    = ST_ROW;
      end

      // One glyph row per beat while the output register is free.
      ST_ROW: begin
        alu_req.a = 13'(cursor_y);
        alu_req.b = 13'(row);
        if (out_free) begin
          res_valid_next  = 1'b1;
          pos_x_next      = cursor_x;
          pos_y_next      = alu_res.value[11:0];
          pixel_mask_next = glyph_ok ? (rev16(ram_rdata) & col_mask) : '0;
          out_color_next  = item_color;
          clear_rest_next = overwrite;
          last_next       = row_last;
          if (row_last) begin
            state_next = ST_ADVANCE;
          end else begin
            row_next = row + 6'd1;
          end
        end
      end

      // Advance one cell.
      ST_ADVANCE: begin
        adv_x_next = alu_res.value[12:0];
        state_next = ST_WRAP;
      end

      // Wrap when the next cell would not fit; overwrite is kept.
      ST_WRAP: begin
        alu_req.a = adv_x;
        if (alu_res.flag) begin
          nl_post_next = 1'b1;
          state_next   = ST_NEWLINE;
        end else begin
          cursor_x_next = adv_x[11:0];
          state_next    = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cursor_x  <= LEFT_MARGIN_RST;
      cursor_y  <= TOP_MARGIN_RST;
      overwrite <= 1'b0;
      res_valid <= 1'b0;
      row       <= 6'd0;
    end else begin
      state     <= state_next;
      cursor_x  <= cursor_x_next;
      cursor_y  <= cursor_y_next;
      overwrite <= overwrite_next;
      res_valid <= res_valid_next;
      row       <= row_next;
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    nl_post    <= nl_post_next;
    item_code  <= item_code_next;
    item_color <= item_color_next;
    col_mask   <= col_mask_next;
    adv_x      <= adv_x_next;
    pos_x      <= pos_x_next;
    pos_y      <= pos_y_next;
    pixel_mask <= pixel_mask_next;
    out_color  <= out_color_next;
    clear_rest <= clear_rest_next;
    last       <= last_next;
  end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gtc_pkg::*;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PRINT_LIMIT   = 100;

  // One input beat.
  typedef struct packed {
    logic        kind;
    logic [20:0] code;
    logic [4:0]  row;
    logic [15:0] bits;
    logic [31:0] ink;
  } console_req_t;

  // One result beat: a glyph row placed on screen.
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [15:0] mask;
    logic [31:0] color;
    logic        clear;
    logic        is_last;
  } mask_row_t;

  // Directed stimulus line; first_row is the hand-written first result, if typed.
  typedef struct packed {
    console_req_t req;
    logic         typed;
    mask_row_t    first_row;
  } script_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  localparam mask_row_t NO_ROW = '0;

  logic        clk;
  logic        rst        = 1'b1;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [11:0] cfg_data   = '0;
  logic        req_valid  = 1'b0;
  logic        req_stall;
  logic        req_type   = 1'b0;
  logic [20:0] code       = '0;
  logic [4:0]  row_index  = '0;
  logic [15:0] row_bits   = '0;
  logic [31:0] ink_color  = '0;
  logic        res_valid;
  logic        res_stall  = 1'b0;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [15:0] pixel_mask;
  logic [31:0] out_color;
  logic        clear_rest;
  logic        res_last;

  glyph_text_console_renderer u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .code       (code),
    .row_index  (row_index),
    .row_bits   (row_bits),
    .ink_color  (ink_color),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pixel_mask (pixel_mask),
    .out_color  (out_color),
    .clear_rest (clear_rest),
    .last       (res_last)
  );

  // Console state as the block should hold it.
  int reg_fbw, reg_fbh, reg_gw, reg_gh, reg_line, reg_left, reg_top;
  int pen_x, pen_y;
  bit overstrike;
  logic [15:0] font_rows [GLYPH_COUNT_DEF][MAX_GLYPH_ROWS_DEF];
  bit          font_valid [GLYPH_COUNT_DEF][MAX_GLYPH_ROWS_DEF];

  mask_row_t   pending_rows [$];
  script_row_t script [$];
  int          mismatches = 0;
  int          burst_left = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int          stall_span = 0;
  int          rx_cycles  = 0;
  mask_row_t   got_row, want_row;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Glyph size as the block uses it, saturated into the supported range.
  function automatic int cell_width();
    if (reg_gw < 1) return 1;
    if (reg_gw > MAX_GLYPH_WIDTH) return MAX_GLYPH_WIDTH;
    return reg_gw;
  endfunction

  function automatic int cell_height();
    if (reg_gh < 1) return 1;
    if (reg_gh > MAX_GLYPH_ROWS_DEF) return MAX_GLYPH_ROWS_DEF;
    return reg_gh;
  endfunction

  // Glyph that a draw beat reads, or -1 for the cursor-only codes.
  function automatic int glyph_read(input logic [20:0] c);
    if (c > 21'd255) return int'(CH_QUESTION);
    if (c[7:0] == CH_NEWLINE || c[7:0] == CH_RETURN) return -1;
    return int'(c[7:0]);
  endfunction

  function automatic void line_feed();
    pen_x = reg_left;
    pen_y = (pen_y + reg_line > int'(Y_LIMIT)) ? int'(Y_LIMIT) : pen_y + reg_line;
  endfunction

  function automatic void console_reset();
    reg_fbw    = FB_WIDTH_RST;
    reg_fbh    = FB_HEIGHT_RST;
    reg_gw     = GLYPH_WIDTH_RST;
    reg_gh     = GLYPH_HEIGHT_RST;
    reg_line   = LINE_HEIGHT_RST;
    reg_left   = LEFT_MARGIN_RST;
    reg_top    = TOP_MARGIN_RST;
    pen_x      = reg_left;
    pen_y      = reg_top;
    overstrike = 1'b0;
    foreach (font_valid[g, r]) font_valid[g][r] = 1'b0;
  endfunction

  // Applies one accepted beat to the console state and queues the glyph rows it draws.
  function automatic int render_item(input console_req_t s);
    int ch, gw, gh;
    logic [15:0] colmask, glyph;
    mask_row_t mr;
    if (s.kind == REQ_LOAD) begin
      font_rows[s.code[7:0]][s.row]  = s.bits;
      font_valid[s.code[7:0]][s.row] = 1'b1;
      return 0;
    end
    ch = (s.code > 21'd255) ? int'(CH_QUESTION) : int'(s.code[7:0]);
    if (ch == int'(CH_NEWLINE)) begin
      line_feed();
      overstrike = 1'b0;
      return 0;
    end
    if (ch == int'(CH_RETURN)) begin
      pen_x = reg_left;
      overstrike = 1'b1;
      return 0;
    end
    gw = cell_width();
    gh = cell_height();
    // Wrap before drawing when the cell does not fit on this line.
    if (pen_x + gw > reg_fbw) begin
      line_feed();
      overstrike = 1'b0;
    end
    // A cell below the bottom edge is dropped and the cursor stays put.
    if (pen_y + gh > reg_fbh) return 0;
    for (int c = 0; c < 16; c++) colmask[c] = (c < gw) && (pen_x + c < reg_fbw);
    for (int r = 0; r < gh; r++) begin
      glyph = font_rows[ch][r];
      mr.x = 12'(pen_x);
      mr.y = 12'(pen_y + r);
      for (int c = 0; c < 16; c++) mr.mask[c] = glyph[15 - c] & colmask[c];
      mr.color   = s.ink;
      mr.clear   = overstrike;
      mr.is_last = (r == gh - 1);
      pending_rows.push_back(mr);
    end
    pen_x += gw;
    if (pen_x + gw > reg_fbw) line_feed();
    return gh;
  endfunction

  // Sends one beat in the sender's burst pattern and predicts it once accepted.
  task automatic send_item(input console_req_t s, output int produced);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(1, 7);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    req_valid <= 1'b1;
    req_type  <= s.kind;
    code      <= s.code;
    row_index <= s.row;
    row_bits  <= s.bits;
    ink_color <= s.ink;
    do @(posedge clk); while (req_stall !== 1'b0);
    produced = render_item(s);
  endtask

  // Loads any glyph row that a draw would read but that was never written.
  task automatic fill_missing_rows(input logic [20:0] c);
    int g, gh, n;
    console_req_t ld;
    g = glyph_read(c);
    if (g < 0) return;
    gh = cell_height();
    for (int r = 0; r < gh; r++) begin
      if (!font_valid[g][r]) begin
        ld.kind = REQ_LOAD;
        ld.code = {13'($urandom), 8'(g)};
        ld.row  = 5'(r);
        ld.bits = 16'($urandom);
        ld.ink  = $urandom;
        send_item(ld, n);
      end
    end
  endtask

  // Holds the sender off until every expected row has arrived.
  task automatic drain_rows();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_rows.size() != 0) @(posedge clk);
  endtask

  // Drains, then lets cursor-only work inside the block finish.
  task automatic settle();
    drain_rows();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FB_WIDTH:     reg_fbw  = int'(val);
      REG_FB_HEIGHT:    reg_fbh  = int'(val);
      REG_GLYPH_WIDTH:  reg_gw   = int'(val[4:0]);
      REG_GLYPH_HEIGHT: reg_gh   = int'(val[5:0]);
      REG_LINE_HEIGHT:  reg_line = int'(val[6:0]);
      REG_LEFT_MARGIN:  reg_left = int'(val);
      REG_TOP_MARGIN:   reg_top  = int'(val);
      default: ;
    endcase
  endtask

  task automatic apply_config(input int unsigned fbw, input int unsigned fbh,
                              input int unsigned gw, input int unsigned gh,
                              input int unsigned lh, input int unsigned lm,
                              input int unsigned tm);
    write_reg(REG_FB_WIDTH, 12'(fbw));
    write_reg(REG_FB_HEIGHT, 12'(fbh));
    write_reg(REG_GLYPH_WIDTH, 12'(gw));
    write_reg(REG_GLYPH_HEIGHT, 12'(gh));
    write_reg(REG_LINE_HEIGHT, 12'(lh));
    write_reg(REG_LEFT_MARGIN, 12'(lm));
    write_reg(REG_TOP_MARGIN, 12'(tm));
  endtask

  // Mostly draws, many of a few reused glyphs, with loads, cursor codes, wide codes and other byte codes mixed in.
  function automatic console_req_t random_req();
    console_req_t s;
    int pick;
    s.kind = REQ_DRAW;
    s.code = 21'($urandom);
    s.row  = 5'($urandom);
    s.bits = 16'($urandom);
    s.ink  = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 15) s.kind = REQ_LOAD;
    else if (pick < 25) s.code = 21'(CH_NEWLINE);
    else if (pick < 32) s.code = 21'(CH_RETURN);
    else if (pick < 40) s.code = 21'($urandom_range(256, 21'h1FFFFF));
    else if (pick < 55) s.code = 21'($urandom_range(0, 255));
    else begin
      case ($urandom_range(0, 5))
        0: s.code = 21'h41;
        1: s.code = 21'h67;
        2: s.code = 21'h2E;
        3: s.code = 21'h00;
        4: s.code = 21'hFF;
        default: s.code = 21'h5F;
      endcase
    end
    return s;
  endfunction

  task automatic run_phase(input int count);
    console_req_t s;
    int n;
    repeat (count) begin
      s = random_req();
      if (s.kind == REQ_DRAW) fill_missing_rows(s.code);
      send_item(s, n);
      if ($urandom_range(0, 39) == 0) drain_rows();
    end
    settle();
  endtask

  task automatic add_step(input logic kind, input logic [20:0] c, input logic [4:0] r,
                          input logic [15:0] bits, input logic [31:0] ink,
                          input logic typed, input mask_row_t first_row);
    script_row_t sr;
    sr.req       = '{kind, c, r, bits, ink};
    sr.typed     = typed;
    sr.first_row = first_row;
    script.push_back(sr);
  endtask

  task automatic check_row(input mask_row_t got, input mask_row_t want);
    if (got.x !== want.x)
      report($sformatf("pos_x %0d, expected %0d", got.x, want.x));
    if (got.y !== want.y)
      report($sformatf("pos_y %0d, expected %0d", got.y, want.y));
    if (got.mask !== want.mask)
      report($sformatf("pixel_mask %h, expected %h at y %0d", got.mask, want.mask, want.y));
    if (got.color !== want.color)
      report($sformatf("out_color %h, expected %h", got.color, want.color));
    if (got.clear !== want.clear)
      report($sformatf("clear_rest %b, expected %b", got.clear, want.clear));
    if (got.is_last !== want.is_last)
      report($sformatf("last %b, expected %b at y %0d", got.is_last, want.is_last, want.y));
  endtask

  // Result side: check each accepted beat, then pick the next stall value.
  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && !res_stall) begin
      got_row = '{pos_x, pos_y, pixel_mask, out_color, clear_rest, res_last};
      if (pending_rows.size() == 0) begin
        report($sformatf("result beat at x %0d y %0d with nothing expected", pos_x, pos_y));
      end else begin
        want_row = pending_rows.pop_front();
        check_row(got_row, want_row);
      end
    end
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_span = $urandom_range(16, 160);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      STALL_NONE:  res_stall <= 1'b0;
      STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
      default:     res_stall <= (rx_cycles % 3 == 0);
    endcase
    rx_cycles++;
  end

  // Watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("glyph_text_console_renderer test failed");
    $finish;
  end

  initial begin
    int n;
    console_reset();

    // Glyph 'A' rows 0 and 1 and a few extreme loads; upper code bits are ignored on loads.
    add_step(REQ_LOAD, 21'h1FFF41, 5'd0, 16'hFF00, 32'hFFFFFFFF, 1'b0, NO_ROW);
    add_step(REQ_LOAD, 21'h000041, 5'd1, 16'h00FF, 32'h00000000, 1'b0, NO_ROW);
    add_step(REQ_LOAD, 21'h000000, 5'd31, 16'hFFFF, 32'h12345678, 1'b0, NO_ROW);
    add_step(REQ_LOAD, 21'h0000FF, 5'd0, 16'h8001, 32'h00000000, 1'b0, NO_ROW);
    // First cells at the reset cursor, then carriage return turns on overwrite.
    add_step(REQ_DRAW, 21'h41, 5'd0, 16'h0000, 32'h00000000, 1'b1,
             mask_row_t'{12'd20, 12'd15, 16'h00FF, 32'h00000000, 1'b0, 1'b0});
    add_step(REQ_DRAW, 21'h41, 5'd31, 16'hFFFF, 32'hFFFFFFFF, 1'b1,
             mask_row_t'{12'd28, 12'd15, 16'h00FF, 32'hFFFFFFFF, 1'b0, 1'b0});
    add_step(REQ_DRAW, 21'(CH_RETURN), 5'd0, 16'h0000, 32'h0, 1'b0, NO_ROW);
    add_step(REQ_DRAW, 21'h41, 5'd0, 16'h0000, 32'hA5A5A5A5, 1'b1,
             mask_row_t'{12'd20, 12'd15, 16'h00FF, 32'hA5A5A5A5, 1'b1, 1'b0});
    add_step(REQ_DRAW, 21'(CH_NEWLINE), 5'd0, 16'h0000, 32'h0, 1'b0, NO_ROW);
    add_step(REQ_DRAW, 21'hFF, 5'd0, 16'h0000, 32'h5A5A5A5A, 1'b1,
             mask_row_t'{12'd20, 12'd31, 16'h0001, 32'h5A5A5A5A, 1'b0, 1'b0});
    // Codes above 255 all draw as '?', even when their low byte is a cursor code.
    add_step(REQ_DRAW, 21'h1FFFFF, 5'd0, 16'h0000, 32'h0F0F0F0F, 1'b0, NO_ROW);
    add_step(REQ_DRAW, 21'h000100, 5'd0, 16'h0000, 32'hF0F0F0F0, 1'b0, NO_ROW);
    add_step(REQ_DRAW, 21'h00010A, 5'd0, 16'h0000, 32'h11111111, 1'b0, NO_ROW);
    add_step(REQ_DRAW, 21'h00010D, 5'd0, 16'h0000, 32'h22222222, 1'b0, NO_ROW);
    add_step(REQ_DRAW, 21'h000000, 5'd0, 16'h0000, 32'h33333333, 1'b0, NO_ROW);
    // Overwrite again, then newline clears it.
    add_step(REQ_DRAW, 21'(CH_RETURN), 5'd0, 16'h0000, 32'h0, 1'b0, NO_ROW);
    add_step(REQ_DRAW, 21'h41, 5'd0, 16'h0000, 32'h44444444, 1'b0, NO_ROW);
    add_step(REQ_DRAW, 21'(CH_NEWLINE), 5'd0, 16'h0000, 32'h0, 1'b0, NO_ROW);
    add_step(REQ_DRAW, 21'h41, 5'd0, 16'h0000, 32'h55555555, 1'b1,
             mask_row_t'{12'd20, 12'd47, 16'h00FF, 32'h55555555, 1'b0, 1'b0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].req.kind == REQ_DRAW) fill_missing_rows(script[i].req.code);
      send_item(script[i].req, n);
      if (script[i].typed && n > 0) pending_rows[pending_rows.size() - n] = script[i].first_row;
    end
    settle();

    // Narrow screen: frequent wraps.
    apply_config(50, 4095, 7, 5, 3, 30, 0);
    run_phase(15);
    // Left margin near the right edge: cells drawn partly off screen.
    apply_config(50, 4095, 9, 3, 2, 45, 4095);
    run_phase(10);
    // Zero width screen and zero-sized glyphs; upper data bits beyond each register.
    apply_config(0, 4095, 12'hFE0, 12'hFC0, 12'hF80, 0, 0);
    run_phase(10);
    // Largest glyphs and screen.
    apply_config(4095, 4095, 31, 63, 1, 0, 4095);
    run_phase(6);
    apply_config($urandom_range(100, 700), 4095, 16, 2, $urandom_range(1, 20),
                 $urandom_range(0, 50), 15);
    run_phase(25);
    // Bottom edge just below the cursor.
    apply_config(640, (pen_y + 20 > 4095) ? 4095 : pen_y + 20, 8, 6, 5, 20, 15);
    run_phase(10);
    apply_config(640, 1, 8, 6, 5, 20, 15);
    run_phase(4);
    // Tall line steps drive the cursor into saturation at the bottom.
    apply_config(40, 4095, 8, 1, 127, 30, 4000);
    run_phase(12);

    if (mismatches == 0) begin
      $display("glyph_text_console_renderer test passed");
    end else begin
      $display("glyph_text_console_renderer test failed");
    end
    $finish;
  end

endmodule
